### rtl/core/greedy_min_conflict_graph_colorer_defines.svh
// Assertion macros shared by the colorer's checker.
// No dependencies; included by the checker file.
`ifndef GREEDY_MIN_CONFLICT_GRAPH_COLORER_DEFINES_SVH
`define GREEDY_MIN_CONFLICT_GRAPH_COLORER_DEFINES_SVH

// Clocked assertion, disabled while reset is asserted.
`define GMCC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define GMCC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

### rtl/core/gmcc_pkg.sv
// Shared types and codes for the greedy min-conflict graph colorer.
// No dependencies.
`default_nettype none

package gmcc_pkg;

  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_ADD   = 2'd1,
    CMD_SOLVE = 2'd2,
    CMD_READ  = 2'd3
  } cmd_e;

  typedef enum logic {
    REG_NUM_VERTICES = 1'b0,
    REG_NUM_COLORS   = 1'b1
  } cfg_reg_e;

  localparam int unsigned CfgDataW = 9;
  localparam int unsigned ConfW    = 15;
  localparam logic [ConfW-1:0] ConfMax = '1;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] vertex_a;
    logic [7:0] vertex_b;
  } in_beat_t;

  typedef struct packed {
    logic [4:0]       vertex_color;
    logic [ConfW-1:0] conflict_count;
    logic             status;
  } out_beat_t;

endpackage

`default_nettype wire

### rtl/core/gmcc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module gmcc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

### rtl/core/greedy_min_conflict_graph_colorer.sv
// Top level of the greedy min-conflict graph colorer.
// Depends on gmcc_pkg and gmcc_ram.
//
// Commands arrive as input beats and each gives exactly one result beat. The
// adjacency bitmap sits in one RAM of MAX_VERTICES rows of 64-bit words and
// the vertex colors in a second RAM. After reset, and on every clear-graph
// command, a clearing pass writes zero to each bitmap word, one per cycle;
// no input beat is taken during the pass after reset. Add edge does two
// bitmap read-modify-writes when its vertices are distinct and in range,
// and solve is bounded by the single read port of each RAM: it zeroes the
// colors, then per vertex tallies its neighbours' colours and picks a
// colour, then per vertex counts conflicts. One beat is worked on at a time.
`default_nettype none

module greedy_min_conflict_graph_colorer
  import gmcc_pkg::*;
#(
  parameter int unsigned MAX_VERTICES = 256,
  parameter int unsigned MAX_COLORS   = 16
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire in_beat_t      in_data_i,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output out_beat_t          out_data_o,
  input  wire logic          cfg_valid_i,
  output logic               cfg_ready_o,
  input  wire cfg_reg_e      cfg_index_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i
);

  localparam int unsigned VW    = $clog2(MAX_VERTICES);
  localparam int unsigned NW    = $clog2(MAX_VERTICES + 1);
  localparam int unsigned RW    = (MAX_VERTICES + 63) / 64;
  localparam int unsigned WB    = (RW > 1) ? $clog2(RW) : 1;
  localparam int unsigned AW    = VW + WB;
  localparam int unsigned ADEPTH = MAX_VERTICES * (2 ** WB);
  localparam int unsigned SW    = AW + 1;
  localparam int unsigned CW    = $clog2(MAX_COLORS + 1);
  localparam int unsigned TIW   = (MAX_COLORS > 1) ? $clog2(MAX_COLORS) : 1;
  localparam int unsigned UXW   = VW + 6;

  typedef enum logic [15:0] {
    S_IDLE      = 16'b0000_0000_0000_0001,
    S_SWEEP     = 16'b0000_0000_0000_0010,
    S_EDGE_RA   = 16'b0000_0000_0000_0100,
    S_EDGE_WA   = 16'b0000_0000_0000_1000,
    S_EDGE_RB   = 16'b0000_0000_0001_0000,
    S_EDGE_WB   = 16'b0000_0000_0010_0000,
    S_READ      = 16'b0000_0000_0100_0000,
    S_CZERO     = 16'b0000_0000_1000_0000,
    S_COL_SCAN  = 16'b0000_0001_0000_0000,
    S_COL_DRAIN = 16'b0000_0010_0000_0000,
    S_COL_PICK  = 16'b0000_0100_0000_0000,
    S_CNT_RDV   = 16'b0000_1000_0000_0000,
    S_CNT_CAP   = 16'b0001_0000_0000_0000,
    S_CNT_SCAN  = 16'b0010_0000_0000_0000,
    S_CNT_DRAIN = 16'b0100_0000_0000_0000,
    S_DONE      = 16'b1000_0000_0000_0000
  } state_e;

  state_e           state_q, state_d;
  logic [SW-1:0]    sw_q, sw_d;
  logic             sw_col_q, sw_col_d;
  logic [VW-1:0]    a_q, a_d, b_q, b_d;
  logic [NW-1:0]    v_q, v_d, u_q, u_d;
  logic [CW-1:0]    j_q, j_d;
  logic [TIW-1:0]   best_q, best_d;
  logic [7:0]       best_cnt_q, best_cnt_d;
  logic [7:0]       tally_q [MAX_COLORS];
  logic [7:0]       tally_d [MAX_COLORS];
  logic             pipe_vld_q, pipe_vld_d;
  logic [5:0]       pipe_bit_q, pipe_bit_d;
  logic [CW-1:0]    cv_q, cv_d;
  logic [ConfW-1:0] tot_q, tot_d, conf_q, conf_d;
  logic [4:0]       res_color_q, res_color_d;
  logic             res_status_q, res_status_d;
  logic             out_valid_q, out_valid_d;
  out_beat_t        out_data_q, out_data_d;
  logic [8:0]       nv_q;
  logic [4:0]       nc_q;

  logic             adj_we;
  logic [AW-1:0]    adj_waddr, adj_raddr;
  logic [63:0]      adj_wdata, adj_rdata;
  logic             col_we;
  logic [VW-1:0]    col_waddr, col_raddr;
  logic [CW-1:0]    col_wdata, col_rdata;

  logic [NW-1:0]    eff_n;
  logic [CW-1:0]    eff_k;
  logic [UXW-1:0]   u_ext, b_ext, a_ext;
  logic             adj_bit;
  logic [TIW-1:0]   tidx;
  logic [7:0]       tcur;
  logic             a_oob, b_oob;

  gmcc_ram #(.Width(64), .Depth(ADEPTH)) u_adj_ram (
    .clk_i   (clk_i),
    .we_i    (adj_we),
    .waddr_i (adj_waddr),
    .wdata_i (adj_wdata),
    .raddr_i (adj_raddr),
    .rdata_o (adj_rdata)
  );

  gmcc_ram #(.Width(CW), .Depth(MAX_VERTICES)) u_col_ram (
    .clk_i   (clk_i),
    .we_i    (col_we),
    .waddr_i (col_waddr),
    .wdata_i (col_wdata),
    .raddr_i (col_raddr),
    .rdata_o (col_rdata)
  );

  assign eff_n = (32'(nv_q) < MAX_VERTICES) ? NW'(nv_q) : NW'(MAX_VERTICES);
  assign eff_k = (nc_q == 5'd0) ? CW'(1) :
                 (32'(nc_q) < MAX_COLORS) ? CW'(nc_q) : CW'(MAX_COLORS);

  assign u_ext = UXW'(u_q[VW-1:0]);
  assign b_ext = UXW'(b_q);
  assign a_ext = UXW'(a_q);
  assign adj_bit = adj_rdata[pipe_bit_q];
  assign a_oob = 32'(in_data_i.vertex_a) >= 32'(eff_n);
  assign b_oob = 32'(in_data_i.vertex_b) >= 32'(eff_n);

  assign tidx = (state_q == S_COL_PICK) ? j_q[TIW-1:0] : TIW'(col_rdata - CW'(1));
  assign tcur = tally_q[tidx];

  assign in_ready_o  = (state_q == S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  always_comb begin
    state_d      = state_q;
    sw_d         = sw_q;
    sw_col_d     = sw_col_q;
    a_d          = a_q;
    b_d          = b_q;
    v_d          = v_q;
    u_d          = u_q;
    j_d          = j_q;
    best_d       = best_q;
    best_cnt_d   = best_cnt_q;
    tally_d      = tally_q;
    pipe_vld_d   = pipe_vld_q;
    pipe_bit_d   = pipe_bit_q;
    cv_d         = cv_q;
    tot_d        = tot_q;
    conf_d       = conf_q;
    res_color_d  = res_color_q;
    res_status_d = res_status_q;
    out_valid_d  = out_valid_q;
    out_data_d   = out_data_q;
    adj_we       = 1'b0;
    adj_waddr    = '0;
    adj_wdata    = '0;
    adj_raddr    = '0;
    col_we       = 1'b0;
    col_waddr    = '0;
    col_wdata    = '0;
    col_raddr    = '0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    // tally beat of the colouring scan
    if (pipe_vld_q && (state_q == S_COL_SCAN || state_q == S_COL_DRAIN)) begin
      if (adj_bit && col_rdata != '0 && tcur != 8'hff) begin
        tally_d[tidx] = tcur + 8'd1;
      end
    end
    // compare beat of the conflict scan
    if (pipe_vld_q && (state_q == S_CNT_SCAN || state_q == S_CNT_DRAIN)) begin
      if (adj_bit && col_rdata == cv_q && tot_q != ConfMax) begin
        tot_d = tot_q + ConfW'(1);
      end
    end

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          res_color_d  = '0;
          res_status_d = 1'b0;
          a_d = VW'(in_data_i.vertex_a);
          b_d = VW'(in_data_i.vertex_b);
          case (cmd_e'(in_data_i.command))
            CMD_CLEAR: begin
              sw_d    = '0;
              state_d = S_SWEEP;
            end
            CMD_ADD: begin
              if (a_oob || b_oob) begin
                res_status_d = 1'b1;
                state_d      = S_DONE;
              end else if (in_data_i.vertex_a == in_data_i.vertex_b) begin
                state_d = S_DONE;
              end else begin
                state_d = S_EDGE_RA;
              end
            end
            CMD_SOLVE: begin
              sw_d    = '0;
              tot_d   = '0;
              state_d = S_CZERO;
            end
            CMD_READ: begin
              if (a_oob) begin
                res_status_d = 1'b1;
                state_d      = S_DONE;
              end else begin
                col_raddr = VW'(in_data_i.vertex_a);
                state_d   = S_READ;
              end
            end
            default: state_d = S_DONE;
          endcase
        end
      end
      S_SWEEP: begin
        adj_we    = 1'b1;
        adj_waddr = sw_q[AW-1:0];
        if (sw_col_q && 32'(sw_q) < MAX_VERTICES) begin
          col_we    = 1'b1;
          col_waddr = sw_q[VW-1:0];
        end
        sw_d = sw_q + SW'(1);
        if (sw_q == SW'(ADEPTH - 1)) begin
          sw_col_d = 1'b0;
          state_d  = sw_col_q ? S_IDLE : S_DONE;
        end
      end
      S_EDGE_RA: begin
        adj_raddr = {a_q, b_ext[6 +: WB]};
        state_d   = S_EDGE_WA;
      end
      S_EDGE_WA: begin
        adj_we    = 1'b1;
        adj_waddr = {a_q, b_ext[6 +: WB]};
        adj_wdata = adj_rdata | (64'd1 << b_ext[5:0]);
        state_d   = S_EDGE_RB;
      end
      S_EDGE_RB: begin
        adj_raddr = {b_q, a_ext[6 +: WB]};
        state_d   = S_EDGE_WB;
      end
      S_EDGE_WB: begin
        adj_we    = 1'b1;
        adj_waddr = {b_q, a_ext[6 +: WB]};
        adj_wdata = adj_rdata | (64'd1 << a_ext[5:0]);
        state_d   = S_DONE;
      end
      S_READ: begin
        res_color_d = 5'(col_rdata);
        state_d     = S_DONE;
      end
      S_CZERO: begin
        col_we    = 1'b1;
        col_waddr = sw_q[VW-1:0];
        sw_d      = sw_q + SW'(1);
        if (sw_q == SW'(MAX_VERTICES - 1)) begin
          v_d = '0;
          u_d = '0;
          for (int i = 0; i < MAX_COLORS; i++) begin
            tally_d[i] = '0;
          end
          state_d = (eff_n == '0) ? S_CNT_RDV : S_COL_SCAN;
        end
      end
      S_COL_SCAN: begin
        if (u_q == v_q) begin
          pipe_vld_d = 1'b0;
          state_d    = S_COL_DRAIN;
        end else begin
          adj_raddr  = {v_q[VW-1:0], u_ext[6 +: WB]};
          col_raddr  = u_q[VW-1:0];
          pipe_vld_d = 1'b1;
          pipe_bit_d = u_ext[5:0];
          u_d        = u_q + NW'(1);
        end
      end
      S_COL_DRAIN: begin
        pipe_vld_d = 1'b0;
        j_d        = '0;
        best_d     = '0;
        best_cnt_d = '0;
        state_d    = S_COL_PICK;
      end
      S_COL_PICK: begin
        if (j_q == eff_k) begin
          col_we    = 1'b1;
          col_waddr = v_q[VW-1:0];
          col_wdata = CW'(best_q) + CW'(1);
          for (int i = 0; i < MAX_COLORS; i++) begin
            tally_d[i] = '0;
          end
          u_d = '0;
          if (v_q + NW'(1) == eff_n) begin
            v_d     = '0;
            state_d = S_CNT_RDV;
          end else begin
            v_d     = v_q + NW'(1);
            state_d = S_COL_SCAN;
          end
        end else begin
          if (j_q == '0 || tcur <= best_cnt_q) begin
            best_d     = j_q[TIW-1:0];
            best_cnt_d = tcur;
          end
          j_d = j_q + CW'(1);
        end
      end
      S_CNT_RDV: begin
        if (v_q == eff_n) begin
          conf_d  = tot_q;
          state_d = S_DONE;
        end else begin
          col_raddr = v_q[VW-1:0];
          state_d   = S_CNT_CAP;
        end
      end
      S_CNT_CAP: begin
        cv_d    = col_rdata;
        u_d     = v_q + NW'(1);
        state_d = S_CNT_SCAN;
      end
      S_CNT_SCAN: begin
        if (u_q == eff_n) begin
          pipe_vld_d = 1'b0;
          state_d    = S_CNT_DRAIN;
        end else begin
          adj_raddr  = {v_q[VW-1:0], u_ext[6 +: WB]};
          col_raddr  = u_q[VW-1:0];
          pipe_vld_d = 1'b1;
          pipe_bit_d = u_ext[5:0];
          u_d        = u_q + NW'(1);
        end
      end
      S_CNT_DRAIN: begin
        pipe_vld_d = 1'b0;
        v_d        = v_q + NW'(1);
        state_d    = S_CNT_RDV;
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d               = 1'b1;
          out_data_d.vertex_color   = res_color_q;
          out_data_d.conflict_count = conf_q;
          out_data_d.status         = res_status_q;
          state_d                   = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_SWEEP;
      sw_q        <= '0;
      sw_col_q    <= 1'b1;
      pipe_vld_q  <= 1'b0;
      out_valid_q <= 1'b0;
      tot_q       <= '0;
      conf_q      <= '0;
      nv_q        <= 9'd256;
      nc_q        <= 5'd4;
      for (int i = 0; i < MAX_COLORS; i++) begin
        tally_q[i] <= '0;
      end
    end else begin
      state_q     <= state_d;
      sw_q        <= sw_d;
      sw_col_q    <= sw_col_d;
      pipe_vld_q  <= pipe_vld_d;
      out_valid_q <= out_valid_d;
      tot_q       <= tot_d;
      conf_q      <= conf_d;
      tally_q     <= tally_d;
      if (cfg_valid_i) begin
        case (cfg_index_i)
          REG_NUM_VERTICES: nv_q <= cfg_data_i;
          REG_NUM_COLORS:   nc_q <= cfg_data_i[4:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    a_q          <= a_d;
    b_q          <= b_d;
    v_q          <= v_d;
    u_q          <= u_d;
    j_q          <= j_d;
    best_q       <= best_d;
    best_cnt_q   <= best_cnt_d;
    pipe_bit_q   <= pipe_bit_d;
    cv_q         <= cv_d;
    res_color_q  <= res_color_d;
    res_status_q <= res_status_d;
    out_data_q   <= out_data_d;
  end

endmodule

`default_nettype wire

### rtl/core/gmcc_checker.sv
// Port-level checker for the colorer, bound to the top level.
// Depends on gmcc_pkg and greedy_min_conflict_graph_colorer_defines.svh.
`default_nettype none
`include "greedy_min_conflict_graph_colorer_defines.svh"

module gmcc_checker
  import gmcc_pkg::*;
#(
  parameter int unsigned MAX_COLORS = 16
) (
  input wire logic      clk_i,
  input wire logic      rst_ni,
  input wire logic      in_valid_i,
  input wire logic      in_ready_o,
  input wire logic      out_valid_o,
  input wire logic      out_ready_i,
  input wire out_beat_t out_data_o
);

  `GMCC_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o), "result beat dropped or changed while stalled")
  `GMCC_ASSERT(a_oob_colour, out_valid_o && out_data_o.status |-> out_data_o.vertex_color == 5'd0, "flagged beat carries a colour")
  `GMCC_ASSERT(a_colour_range, out_valid_o |-> 32'(out_data_o.vertex_color) <= MAX_COLORS, "colour beyond range")
  `GMCC_ASSERT(a_one_result, in_valid_i && in_ready_o |=> !in_ready_o, "input taken again before its result")
  `GMCC_ASSERT_ALWAYS(a_reset_quiet, !rst_ni |=> !out_valid_o || rst_ni, "result shown during reset")

endmodule

bind greedy_min_conflict_graph_colorer gmcc_checker #(.MAX_COLORS(MAX_COLORS)) u_gmcc_checker (.*);

`default_nettype wire

### test/greedy_min_conflict_graph_colorer_tb.sv
// Self-checking testbench for greedy_min_conflict_graph_colorer: a directed table, then random
// phases of edge loads, solves and reads, checked against an in-bench colouring predictor or,
// for some directed rows, against fixed expected beats. Depends on gmcc_pkg and the colorer RTL.
module greedy_min_conflict_graph_colorer_tb;
  import gmcc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NV_MAX = 256;
  localparam int unsigned NC_MAX = 16;
  localparam int unsigned ITEMS  = 1650;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_beat_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_beat_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  cfg_reg_e cfg_index = REG_NUM_VERTICES;
  logic [CfgDataW-1:0] cfg_data = '0;

  greedy_min_conflict_graph_colorer dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_o(in_ready), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_ready_i(out_ready), .out_data_o(out_data),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  always #10 clk = ~clk;

  // colouring state mirrored by the predictor
  bit             edge_map [NV_MAX][NV_MAX];
  logic [4:0]     vtx_colour [NV_MAX];
  logic [ConfW-1:0] conflicts;
  logic [8:0]     nv_reg;
  logic [4:0]     nc_reg;

  out_beat_t pending_results[$];
  int errors = 0;
  int beats_checked = 0;
  int items_sent = 0;
  int solves = 0;
  int reg_writes = 0;
  bit calm = 1'b0;

  function automatic int unsigned active_vertices();
    return (nv_reg < NV_MAX) ? nv_reg : NV_MAX;
  endfunction

  function automatic int unsigned active_colours();
    if (nc_reg == 0) return 1;
    return (nc_reg < NC_MAX) ? nc_reg : NC_MAX;
  endfunction

  function automatic out_beat_t colour_step(in_beat_t b);
    out_beat_t r;
    int unsigned n, k, best, total;
    int unsigned tally [NC_MAX];
    n = active_vertices();
    k = active_colours();
    r = '0;
    case (cmd_e'(b.command))
      CMD_CLEAR: begin
        foreach (edge_map[i, j]) edge_map[i][j] = 1'b0;
      end
      CMD_ADD: begin
        if (b.vertex_a >= n || b.vertex_b >= n) r.status = 1'b1;
        else if (b.vertex_a != b.vertex_b) begin
          edge_map[b.vertex_a][b.vertex_b] = 1'b1;
          edge_map[b.vertex_b][b.vertex_a] = 1'b1;
        end
      end
      CMD_SOLVE: begin
        foreach (vtx_colour[i]) vtx_colour[i] = '0;
        for (int v = 0; v < n; v++) begin
          for (int j = 0; j < NC_MAX; j++) tally[j] = 0;
          for (int u = 0; u < n; u++)
            if (u != v && vtx_colour[u] != 0 && vtx_colour[u] <= k && edge_map[v][u])
              if (tally[vtx_colour[u]-1] < 255) tally[vtx_colour[u]-1]++;
          best = 0;
          for (int j = 0; j < k; j++)
            if (tally[j] <= tally[best]) best = j;
          vtx_colour[v] = 5'(best + 1);
        end
        total = 0;
        for (int v = 0; v < n; v++)
          for (int u = v + 1; u < n; u++)
            if (edge_map[v][u] && vtx_colour[u] == vtx_colour[v] && total < 32767) total++;
        conflicts = ConfW'(total);
      end
      default: begin
        if (b.vertex_a >= n) r.status = 1'b1;
        else r.vertex_color = vtx_colour[b.vertex_a];
      end
    endcase
    r.conflict_count = conflicts;
    return r;
  endfunction

  task automatic flag_mismatch(string what);
    $display("MISMATCH at %0t: %s", $realtime, what);
    errors++;
  endtask

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        flag_mismatch("result beat with nothing expected");
      end else begin
        out_beat_t w;
        w = pending_results.pop_front();
        beats_checked++;
        if (out_data.vertex_color !== w.vertex_color)
          flag_mismatch($sformatf("vertex_color %0d, want %0d", out_data.vertex_color,
                                  w.vertex_color));
        if (out_data.conflict_count !== w.conflict_count)
          flag_mismatch($sformatf("conflict_count %0d, want %0d", out_data.conflict_count,
                                  w.conflict_count));
        if (out_data.status !== w.status)
          flag_mismatch($sformatf("status %0d, want %0d", out_data.status, w.status));
      end
    end
  end

  always @(negedge clk) begin
    out_ready <= calm ? 1'b1 : ($urandom_range(99) >= 13);
  end

  task automatic send_beat(in_beat_t b, bit typed = 1'b0, out_beat_t want = '0);
    out_beat_t p;
    @(negedge clk);
    while (!calm && $urandom_range(99) < 13) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data = b;
    do @(posedge clk); while (!in_ready);
    p = colour_step(b);
    if (cmd_e'(b.command) == CMD_SOLVE) solves++;
    pending_results.push_back(typed ? want : p);
    items_sent++;
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [CfgDataW-1:0] val);
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_NUM_VERTICES) nv_reg = val;
    else nc_reg = val[4:0];
    reg_writes++;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic in_beat_t mk(cmd_e c, int unsigned a = 0, int unsigned b = 0);
    in_beat_t r;
    r.command = c;
    r.vertex_a = 8'(a);
    r.vertex_b = 8'(b);
    return r;
  endfunction

  function automatic out_beat_t res(int unsigned colour, int unsigned conf, bit st);
    out_beat_t r;
    r.vertex_color = 5'(colour);
    r.conflict_count = ConfW'(conf);
    r.status = st;
    return r;
  endfunction

  typedef struct {
    bit        is_reg;
    cfg_reg_e  idx;
    logic [8:0] val;
    in_beat_t  beat;
    bit        typed;
    out_beat_t want;
  } stim_row_t;

  stim_row_t plan[$];

  task automatic row_cmd(in_beat_t b, bit typed = 1'b0, out_beat_t want = '0);
    plan.push_back('{1'b0, REG_NUM_VERTICES, 9'd0, b, typed, want});
  endtask

  task automatic row_reg(cfg_reg_e idx, logic [8:0] val);
    plan.push_back('{1'b1, idx, val, '0, 1'b0, '0});
  endtask

  initial begin
    int unsigned n, ne, nr;
    foreach (edge_map[i, j]) edge_map[i][j] = 1'b0;
    foreach (vtx_colour[i]) vtx_colour[i] = '0;
    conflicts = '0;
    nv_reg = 9'd256;
    nc_reg = 5'd4;

    // directed table
    row_cmd(mk(CMD_READ, 0), 1'b1, res(0, 0, 1'b0));
    row_cmd(mk(CMD_READ, 255), 1'b1, res(0, 0, 1'b0));
    row_cmd(mk(CMD_ADD, 0, 255), 1'b1, res(0, 0, 1'b0));
    row_cmd(mk(CMD_ADD, 5, 5), 1'b1, res(0, 0, 1'b0));
    row_cmd(mk(CMD_ADD, 255, 0), 1'b1, res(0, 0, 1'b0));
    row_cmd(mk(CMD_SOLVE));
    row_cmd(mk(CMD_READ, 0));
    row_cmd(mk(CMD_READ, 255));
    row_reg(REG_NUM_VERTICES, 9'd8);
    row_cmd(mk(CMD_ADD, 8, 1));
    row_cmd(mk(CMD_ADD, 1, 9));
    row_cmd(mk(CMD_READ, 200));
    row_cmd(mk(CMD_ADD, 7, 0));
    row_cmd(mk(CMD_ADD, 1, 2));
    row_reg(REG_NUM_COLORS, 9'd1);
    row_cmd(mk(CMD_SOLVE));
    row_cmd(mk(CMD_READ, 7));
    row_reg(REG_NUM_COLORS, 9'd0);
    row_cmd(mk(CMD_SOLVE));
    row_reg(REG_NUM_COLORS, 9'h1F3);
    row_cmd(mk(CMD_SOLVE));
    row_cmd(mk(CMD_READ, 2));
    row_cmd(mk(CMD_CLEAR));
    row_cmd(mk(CMD_SOLVE));
    row_reg(REG_NUM_VERTICES, 9'd0);
    row_cmd(mk(CMD_SOLVE), 1'b1, res(0, 0, 1'b0));
    row_cmd(mk(CMD_READ, 0), 1'b1, res(0, 0, 1'b1));
    row_reg(REG_NUM_VERTICES, 9'h1FF);
    row_reg(REG_NUM_COLORS, 9'd16);

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (plan[i]) begin
      if (plan[i].is_reg) write_reg(plan[i].idx, plan[i].val);
      else send_beat(plan[i].beat, plan[i].typed, plan[i].want);
    end

    // random phases: configure, load edges, solve, read back
    for (int ph = 0; items_sent < ITEMS; ph++) begin
      bit big;
      big = (ph == 4 || ph == 13);
      calm = (ph >= 6 && ph <= 8);
      if (big) write_reg(REG_NUM_VERTICES, ($urandom_range(1)) ? 9'd256 : 9'h1A5);
      else if (ph == 9) write_reg(REG_NUM_VERTICES, 9'd0);
      else if (ph == 10) write_reg(REG_NUM_VERTICES, 9'd1);
      else write_reg(REG_NUM_VERTICES, 9'($urandom_range(40, 2)));
      write_reg(REG_NUM_COLORS, {4'($urandom), ($urandom_range(4) == 0) ?
                5'($urandom) : 5'($urandom_range(16, 1))});
      n = active_vertices();
      if ($urandom_range(3) == 0) send_beat(mk(CMD_CLEAR));
      ne = big ? 400 : $urandom_range(60, 5);
      for (int e = 0; e < ne; e++) begin
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 8 || n == 0)
          send_beat(mk(CMD_ADD, $urandom_range(255), $urandom_range(255)));
        else if (pick < 11) begin
          int unsigned s;
          s = $urandom_range(n - 1);
          send_beat(mk(CMD_ADD, s, s));
        end else if (pick < 14)
          send_beat(mk(cmd_e'($urandom_range(3) == 0 ? CMD_CLEAR : CMD_READ),
                       $urandom_range(255), $urandom_range(255)));
        else
          send_beat(mk(CMD_ADD, $urandom_range(n - 1), $urandom_range(n - 1)));
      end
      for (int s = 0; s < (($urandom_range(2) == 0 && !big) ? 2 : 1); s++) begin
        send_beat(mk(CMD_SOLVE, $urandom_range(255), $urandom_range(255)));
        nr = (n / 2) + 5;
        for (int r = 0; r < nr; r++) begin
          if (n == 0 || $urandom_range(9) == 0)
            send_beat(mk(CMD_READ, $urandom_range(255), $urandom_range(255)));
          else
            send_beat(mk(CMD_READ, $urandom_range(n - 1), $urandom_range(255)));
        end
        if (n > 1 && !big)
          for (int e = 0; e < 6; e++)
            send_beat(mk(CMD_ADD, $urandom_range(n - 1), $urandom_range(n - 1)));
      end
    end

    @(negedge clk);
    in_valid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (50) @(posedge clk);
    $display("covered %0d commands, %0d solves, %0d register writes", items_sent, solves,
             reg_writes);
    $display("%0d result beats checked, %0d mismatches", beats_checked, errors);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #40ms;
    $display("timeout with %0d results outstanding", pending_results.size());
    $display("status: fail");
    $finish;
  end

endmodule
